@@ hw/rtl/sample_channel_mixer_top_macros.svh @@
// assertion macros for the sample channel mixer
// expects clk and arst_n in the scope where a macro is used
`ifndef SAMPLE_CHANNEL_MIXER_TOP_MACROS_SVH
`define SAMPLE_CHANNEL_MIXER_TOP_MACROS_SVH

// property that must hold at every edge out of reset
`define SCM_CHECK(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// condition in one cycle implies a consequence in the next
`define SCM_CHECK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/scm_pkg.sv @@
// shared constants, types and helpers for the sample channel mixer
// no dependencies
`default_nettype none

package scm_pkg;

	localparam int CHANNELS    = 8;
	localparam int MAX_SAMPLES = 4096;
	localparam int SCALING     = 2;

	localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int IDX_W  = $clog2(MAX_SAMPLES);
	localparam int SUB_W  = (SCALING > 1) ? $clog2(SCALING) : 1;
	localparam int REM_W  = $clog2(MAX_SAMPLES * SCALING + 1);
	localparam int ADDR_W = $clog2(CHANNELS * MAX_SAMPLES);
	localparam int GAIN_W = 9;
	localparam int GP_W   = 2 * GAIN_W;
	localparam int PROD_W = 8 + GP_W + 1;
	localparam int MUS_P_W = 16 + GAIN_W + 1;
	localparam int ACC_W  = 20;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_START = 2'd1;
	localparam logic [1:0] OP_FRAME = 2'd2;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_SOUND_EN    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MUTE        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MUSIC_SCALE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MUSIC_GAIN  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_EFFECT_GAIN = 3'd4;

	localparam logic [GAIN_W-1:0] GAIN_UNITY      = 9'd256;
	localparam logic [GAIN_W-1:0] EFFECT_GAIN_MAX = 9'd384;

	localparam logic signed [15:0] SAT_HI = 16'sh7fff;
	localparam logic signed [15:0] SAT_LO = -16'sh8000;

	typedef struct packed {
		logic [1:0]         opcode;
		logic [2:0]         channel;
		logic [11:0]        sample_index;
		logic [7:0]         sample_byte;
		logic [12:0]        length;
		logic [8:0]         channel_volume;
		logic signed [15:0] music_left;
		logic signed [15:0] music_right;
	} item_t;

	typedef struct packed {
		logic signed [15:0] out_left;
		logic signed [15:0] out_right;
	} result_t;

	typedef struct packed {
		logic [REM_W-1:0]  remaining;
		logic [IDX_W-1:0]  idx;
		logic [SUB_W-1:0]  sub;
		logic [GAIN_W-1:0] gain;
	} chan_state_t;

	typedef struct packed {
		logic              mute;
		logic              music_scale_on;
		logic [GAIN_W-1:0] music_gain;
		logic [GAIN_W-1:0] effect_gain;
	} mix_cfg_t;

	function automatic logic signed [15:0] sat16(input logic signed [ACC_W-1:0] v);
		logic signed [15:0] r;
		if (v > ACC_W'(SAT_HI))
			r = SAT_HI;
		else if (v <= ACC_W'(SAT_LO))
			r = SAT_LO;
		else
			r = v[15:0];
		return r;
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/scm_chan_mem.sv @@
// per-channel play state memory, one write and one registered read port
// entries read as idle until first written; depends on scm_pkg
`default_nettype none

module scm_chan_mem
	import scm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [CH_W-1:0]   wr_addr,
	input  chan_state_t       wr_data,
	input  logic              rd_en,
	input  logic [CH_W-1:0]   rd_addr,
	output chan_state_t       rd_data
);

	chan_state_t mem_q [CHANNELS];
	chan_state_t rd_q;
	logic [CHANNELS-1:0] valid_q;
	logic rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_addr] <= wr_data;
		if (rd_en)
			rd_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en)
				valid_q[wr_addr] <= 1'b1;
			if (rd_en)
				rd_valid_q <= valid_q[rd_addr];
		end
	end

	assign rd_data = rd_valid_q ? rd_q : '0;

endmodule

`default_nettype wire

@@ hw/rtl/scm_sample_mem.sv @@
// effect sample store, one write port and one registered read port
// depends on scm_pkg
`default_nettype none

module scm_sample_mem
	import scm_pkg::*;
(
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [7:0]        wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [7:0]        rd_data
);

	localparam int DEPTH = CHANNELS * MAX_SAMPLES;

	logic [7:0] mem_q [DEPTH];
	logic [7:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_addr] <= wr_data;
		if (rd_en)
			rd_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_q;

endmodule

`default_nettype wire

@@ hw/rtl/scm_mixer.sv @@
// frame engine: music scaling, then one channel per cycle through a
// read-modify-write pipeline on the channel and sample memories; depends on scm_pkg
`default_nettype none

module scm_mixer
	import scm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [15:0] music_left,
	input  logic signed [15:0] music_right,
	input  mix_cfg_t           cfg,
	output logic               done,
	output logic signed [15:0] left,
	output logic signed [15:0] right,
	output logic               crd_en,
	output logic [CH_W-1:0]    crd_addr,
	input  chan_state_t        crd_data,
	output logic               cwr_en,
	output logic [CH_W-1:0]    cwr_addr,
	output chan_state_t        cwr_data,
	output logic               srd_en,
	output logic [ADDR_W-1:0]  srd_addr,
	input  logic [7:0]         srd_data
);

	logic issue_q, mus_pend_q, done_q, played_q;
	logic [CH_W-1:0] rd_ch_q;
	logic signed [MUS_P_W-1:0] pl_q, pr_q;
	logic signed [15:0] left_q, right_q;

	logic v_s1, last_s1;
	logic [CH_W-1:0] ch_s1;
	logic v_s2, act_s2, last_s2;
	logic [GP_W-1:0] gp_s2;
	logic v_s3, act_s3, last_s3;
	logic signed [PROD_W-1:0] prod_s3;

	logic [GAIN_W-1:0] g_mus, fx;
	logic act1;
	chan_state_t nxt;
	logic signed [MUS_P_W-1:0] pl_adj, pr_adj;
	logic signed [PROD_W-1:0] prod_adj;
	logic signed [ACC_W-1:0] acc_sum;

	// scaling off is the same as unity gain
	assign g_mus = !cfg.music_scale_on ? GAIN_UNITY : (cfg.mute ? '0 : cfg.music_gain);
	assign fx    = cfg.mute ? '0 : cfg.effect_gain;

	assign crd_en   = issue_q;
	assign crd_addr = rd_ch_q;

	// s1: advance the channel and fetch its current sample
	always_comb begin
		act1 = v_s1 && (crd_data.remaining != '0);
		nxt  = crd_data;
		nxt.remaining = crd_data.remaining - REM_W'(1);
		if (crd_data.sub == SUB_W'(SCALING - 1)) begin
			nxt.sub = '0;
			nxt.idx = crd_data.idx + IDX_W'(1);
		end else begin
			nxt.sub = crd_data.sub + SUB_W'(1);
		end
		if (nxt.remaining == '0) begin
			nxt.idx = '0;
			nxt.sub = '0;
		end
	end

	assign cwr_en   = act1;
	assign cwr_addr = ch_s1;
	assign cwr_data = nxt;
	assign srd_en   = act1;
	assign srd_addr = ADDR_W'(32'(ch_s1) * MAX_SAMPLES + 32'(crd_data.idx));

	// truncate toward zero on the divide by 256
	assign pl_adj   = pl_q + (pl_q[MUS_P_W-1] ? MUS_P_W'(255) : '0);
	assign pr_adj   = pr_q + (pr_q[MUS_P_W-1] ? MUS_P_W'(255) : '0);
	assign prod_adj = prod_s3 + (prod_s3[PROD_W-1] ? PROD_W'(255) : '0);
	assign acc_sum  = ACC_W'(left_q) + ACC_W'($signed(prod_adj[PROD_W-1:8]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q    <= 1'b0;
			mus_pend_q <= 1'b0;
			done_q     <= 1'b0;
			rd_ch_q    <= '0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			v_s3       <= 1'b0;
			act_s2     <= 1'b0;
			act_s3     <= 1'b0;
			played_q   <= 1'b0;
		end else begin
			mus_pend_q <= start;
			done_q     <= v_s3 && last_s3;
			if (start) begin
				issue_q  <= 1'b1;
				rd_ch_q  <= '0;
				played_q <= 1'b0;
			end else if (issue_q) begin
				rd_ch_q <= rd_ch_q + CH_W'(1);
				if (rd_ch_q == CH_W'(CHANNELS - 1))
					issue_q <= 1'b0;
			end
			v_s1   <= issue_q;
			v_s2   <= v_s1;
			act_s2 <= act1;
			v_s3   <= v_s2;
			act_s3 <= act_s2;
			if (act_s3)
				played_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			pl_q <= MUS_P_W'(music_left) * MUS_P_W'($signed({1'b0, g_mus}));
			pr_q <= MUS_P_W'(music_right) * MUS_P_W'($signed({1'b0, g_mus}));
		end
		ch_s1   <= rd_ch_q;
		last_s1 <= rd_ch_q == CH_W'(CHANNELS - 1);
		gp_s2   <= GP_W'(fx) * GP_W'(crd_data.gain);
		last_s2 <= last_s1;
		prod_s3 <= PROD_W'($signed(srd_data)) * PROD_W'($signed({1'b0, gp_s2}));
		last_s3 <= last_s2;
		if (mus_pend_q) begin
			left_q  <= sat16(ACC_W'($signed(pl_adj[MUS_P_W-1:8])));
			right_q <= sat16(ACC_W'($signed(pr_adj[MUS_P_W-1:8])));
		end else if (act_s3) begin
			left_q <= sat16(acc_sum);
		end
	end

	assign done  = done_q;
	assign left  = left_q;
	assign right = played_q ? left_q : right_q;

endmodule

`default_nettype wire

@@ hw/rtl/sample_channel_mixer_top.sv @@
// top level of the sample channel mixer: handshakes, config registers,
// sequencing and result register; depends on scm_pkg, scm_chan_mem,
// scm_sample_mem, scm_mixer and sample_channel_mixer_top_macros.svh
//
// usage
//   item channel (item_valid / item_ready / item): one transfer carries a
//   write, start or frame item. write and start items finish in the cycle of
//   their transfer, so the next item may follow at once.
//   a frame item runs the mixer: music scaling first, then one channel
//   per cycle through a four-stage read-modify-write pipeline on the channel
//   state memory and the sample memory. item_ready stays low from the frame
//   transfer until the result is loaded into the result register, and the
//   next item may be taken in the cycle that the result becomes valid.
//   result channel (result_valid / result_ready / result): one transfer per
//   frame. a held result does not block write or start items; a following
//   frame waits at its end until the result register frees up.
//   config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): always
//   ready; writes are meant for idle periods only.
//   reset clears the config to its defaults and marks every channel idle. the
//   sample store is not cleared and holds nothing useful until written.
`default_nettype none
`include "sample_channel_mixer_top_macros.svh"

module sample_channel_mixer_top
	import scm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  item_t                item,
	output logic                 result_valid,
	input  logic                 result_ready,
	output result_t              result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [GAIN_W-1:0]    cfg_data
);

	// sequencer states
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MIX  = 2'd1;
	localparam logic [1:0] ST_OUT  = 2'd2;

	logic [1:0] state_q;

	// config registers
	logic sound_en_q, mute_q, scale_q;
	logic [GAIN_W-1:0] mgain_q, egain_q;
	mix_cfg_t mix_cfg;

	// result register
	result_t result_q;
	logic result_valid_q;
	logic load;

	// item decode
	logic xfer, ch_ok, idx_ok;
	logic swr_en, start_wr, frame_go;
	logic [ADDR_W-1:0] swr_addr;
	logic [31:0] len_sat;
	chan_state_t start_data;

	// memory ports
	logic mix_done;
	logic signed [15:0] mix_left, mix_right;
	logic crd_en, mix_cwr_en, srd_en;
	logic [CH_W-1:0] crd_addr, mix_cwr_addr;
	chan_state_t crd_data, mix_cwr_data;
	logic [ADDR_W-1:0] srd_addr;
	logic [7:0] srd_data;
	logic cwr_en;
	logic [CH_W-1:0] cwr_addr;
	chan_state_t cwr_data;

	assign item_ready = (state_q == ST_IDLE);
	assign xfer       = item_valid && item_ready;
	assign ch_ok      = 32'(item.channel) < CHANNELS;
	assign idx_ok     = 32'(item.sample_index) < MAX_SAMPLES;

	// writes and starts are dropped while sound is off, frames always mix
	assign swr_en   = xfer && (item.opcode == OP_WRITE) && sound_en_q && ch_ok && idx_ok;
	assign start_wr = xfer && (item.opcode == OP_START) && sound_en_q && ch_ok;
	assign frame_go = xfer && (item.opcode == OP_FRAME);
	assign swr_addr = ADDR_W'(32'(item.channel) * MAX_SAMPLES + 32'(item.sample_index));

	// long lengths clamp to the store size; zero length leaves the channel idle
	always_comb begin
		len_sat = (32'(item.length) > MAX_SAMPLES) ? MAX_SAMPLES : 32'(item.length);
		start_data.remaining = REM_W'(len_sat * SCALING);
		start_data.idx       = '0;
		start_data.sub       = '0;
		start_data.gain      = item.channel_volume;
	end

	// start items own the write port when idle, the mixer while it runs
	assign cwr_en   = start_wr || mix_cwr_en;
	assign cwr_addr = start_wr ? CH_W'(item.channel) : mix_cwr_addr;
	assign cwr_data = start_wr ? start_data : mix_cwr_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sound_en_q <= 1'b1;
			mute_q     <= 1'b0;
			scale_q    <= 1'b0;
			mgain_q    <= GAIN_UNITY;
			egain_q    <= GAIN_UNITY;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_SOUND_EN:    sound_en_q <= cfg_data[0];
				CFG_MUTE:        mute_q     <= cfg_data[0];
				CFG_MUSIC_SCALE: scale_q    <= cfg_data[0];
				CFG_MUSIC_GAIN:  mgain_q    <= cfg_data;
				// effect master gain saturates at 1.5
				CFG_EFFECT_GAIN: egain_q    <= (cfg_data > EFFECT_GAIN_MAX) ?
						EFFECT_GAIN_MAX : cfg_data;
				default: ;
			endcase
		end
	end

	assign mix_cfg = '{mute: mute_q, music_scale_on: scale_q,
			music_gain: mgain_q, effect_gain: egain_q};

	// sequencer: idle -> mix until the last channel lands -> hand off result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (frame_go) state_q <= ST_MIX;
				ST_MIX:  if (mix_done) state_q <= ST_OUT;
				ST_OUT:  if (load)     state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result register frees the mixer from a stalled receiver
	assign load = (state_q == ST_OUT) && (!result_valid_q || result_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (load) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			result_q <= '{out_left: mix_left, out_right: mix_right};
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	scm_chan_mem u_chan_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cwr_en),
		.wr_addr (cwr_addr),
		.wr_data (cwr_data),
		.rd_en   (crd_en),
		.rd_addr (crd_addr),
		.rd_data (crd_data)
	);

	scm_sample_mem u_sample_mem (
		.clk     (clk),
		.wr_en   (swr_en),
		.wr_addr (swr_addr),
		.wr_data (item.sample_byte),
		.rd_en   (srd_en),
		.rd_addr (srd_addr),
		.rd_data (srd_data)
	);

	scm_mixer u_mixer (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (frame_go),
		.music_left  (item.music_left),
		.music_right (item.music_right),
		.cfg         (mix_cfg),
		.done        (mix_done),
		.left        (mix_left),
		.right       (mix_right),
		.crd_en      (crd_en),
		.crd_addr    (crd_addr),
		.crd_data    (crd_data),
		.cwr_en      (mix_cwr_en),
		.cwr_addr    (mix_cwr_addr),
		.cwr_data    (mix_cwr_data),
		.srd_en      (srd_en),
		.srd_addr    (srd_addr),
		.srd_data    (srd_data)
	);

	// start writes and mixer writeback never collide on the channel memory
	`SCM_CHECK(a_chan_wr_single, !(start_wr && mix_cwr_en), "channel memory write collision")
	// writeback only happens inside a frame
	`SCM_CHECK(a_wb_in_mix, mix_cwr_en |-> (state_q == ST_MIX), "writeback outside a frame")
	// mixer completion only while the sequencer waits for it
	`SCM_CHECK(a_done_in_mix, mix_done |-> (state_q == ST_MIX), "mixer done outside a frame")
	// a frame transfer always moves the sequencer into mixing
	`SCM_CHECK_NEXT(a_frame_mix, frame_go, (state_q == ST_MIX), "frame did not start mixing")

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// self-checking testbench for sample_channel_mixer_top: directed corner cases, a stall-free
// burst and randomized phases under changing mixer settings
// depends on scm_pkg and sample_channel_mixer_top
`timescale 1ns / 1ps

module testbench;
	import scm_pkg::*;

	// opcode with no meaning, must be dropped without a result
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int STORE_DEPTH = CHANNELS * MAX_SAMPLES;
	localparam int LENGTH_MAX = 8191;
	// settle time after the owed frames, enough to cover any trailing work
	localparam int SETTLE_CYCLES = 3 * (CHANNELS + 6);
	localparam int PHASE_ITEMS = 110;
	localparam int RANDOM_ITEMS = 1300;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 item_valid = 1'b0;
	logic                 item_ready;
	item_t                item = '0;
	logic                 result_valid;
	logic                 result_ready = 1'b0;
	result_t              result;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [GAIN_W-1:0]    cfg_data = '0;

	sample_channel_mixer_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// shadow of the mixer: sample store, per-channel playback, settings
	logic [7:0]        sample_mem [STORE_DEPTH];
	bit                sample_known [STORE_DEPTH];
	int unsigned       frames_left [CHANNELS];
	int unsigned       play_pos [CHANNELS];
	logic [GAIN_W-1:0] chan_volume [CHANNELS];
	logic              sound_on;
	logic              muted;
	logic              music_scaling;
	logic [GAIN_W-1:0] music_gain_q8;
	logic [GAIN_W-1:0] effect_gain_q8;

	// mixed frames still owed by the block, oldest first
	result_t expected_mix [$];
	result_t oldest_mix;
	int      mismatches = 0;
	int      counted_items = 0;
	// when set, neither side inserts idle cycles
	bit      stall_free = 1'b0;

	always #1 clk = ~clk;

	// receiver backpressure, changes on the falling edge
	always @(negedge clk)
		result_ready <= stall_free || ($urandom_range(99) >= 13);

	// compare every result transfer with the oldest predicted frame
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (expected_mix.size() == 0) begin
				$error("result transfer with no frame pending: out_left %0d out_right %0d",
					result.out_left, result.out_right);
				mismatches++;
			end else begin
				oldest_mix = expected_mix.pop_front();
				if (result.out_left !== oldest_mix.out_left) begin
					$error("out_left expected %0d actual %0d",
						oldest_mix.out_left, result.out_left);
					mismatches++;
				end
				if (result.out_right !== oldest_mix.out_right) begin
					$error("out_right expected %0d actual %0d",
						oldest_mix.out_right, result.out_right);
					mismatches++;
				end
			end
		end
	end

	function automatic void reset_model();
		for (int a = 0; a < STORE_DEPTH; a++)
			sample_known[a] = 1'b0;
		for (int c = 0; c < CHANNELS; c++) begin
			frames_left[c] = 0;
			play_pos[c] = 0;
			chan_volume[c] = '0;
		end
		sound_on = 1'b1;
		muted = 1'b0;
		music_scaling = 1'b0;
		music_gain_q8 = GAIN_UNITY;
		effect_gain_q8 = GAIN_UNITY;
	endfunction

	function automatic void store_setting(input logic [CFG_IDX_W-1:0] idx,
		input logic [GAIN_W-1:0] val);
		case (idx)
			CFG_SOUND_EN:    sound_on = val[0];
			CFG_MUTE:        muted = val[0];
			CFG_MUSIC_SCALE: music_scaling = val[0];
			CFG_MUSIC_GAIN:  music_gain_q8 = val;
			// effect gain tops out at 1.5
			CFG_EFFECT_GAIN: effect_gain_q8 = (val > EFFECT_GAIN_MAX) ? EFFECT_GAIN_MAX : val;
			default: ;
		endcase
	endfunction

	function automatic logic signed [15:0] clamp16(input longint v);
		if (v > longint'(SAT_HI))
			return SAT_HI;
		if (v <= longint'(SAT_LO))
			return SAT_LO;
		return v[15:0];
	endfunction

	// store slot that channel c reads next, each byte held for SCALING frames
	function automatic int unsigned read_slot(input int c);
		int unsigned p;
		p = play_pos[c] / SCALING;
		return (p >= MAX_SAMPLES) ? MAX_SAMPLES - 1 : p;
	endfunction

	// every active channel would read a byte that has been written
	function automatic bit frame_safe();
		for (int c = 0; c < CHANNELS; c++)
			if (frames_left[c] != 0 && !sample_known[c * MAX_SAMPLES + read_slot(c)])
				return 1'b0;
		return 1'b1;
	endfunction

	// music scaling, then channels in order with saturation after each one
	function automatic result_t mix_frame(input item_t it);
		longint  lft;
		longint  rgt;
		longint  fx;
		longint  mg;
		longint  smp;
		longint  term;
		bit      played;
		result_t r;
		lft = longint'(it.music_left);
		rgt = longint'(it.music_right);
		fx = muted ? 64'sd0 : longint'(effect_gain_q8);
		played = 1'b0;
		if (music_scaling) begin
			mg = muted ? 64'sd0 : longint'(music_gain_q8);
			lft = longint'(clamp16((lft * mg) / 256));
			rgt = longint'(clamp16((rgt * mg) / 256));
		end
		for (int c = 0; c < CHANNELS; c++) begin
			if (frames_left[c] == 0)
				continue;
			smp = longint'($signed(sample_mem[c * MAX_SAMPLES + read_slot(c)]));
			// truncation toward zero, same as the signed divide here
			term = (smp * 256 * fx * longint'(chan_volume[c])) / 65536;
			lft = longint'(clamp16(lft + term));
			played = 1'b1;
			play_pos[c]++;
			frames_left[c]--;
			if (frames_left[c] == 0)
				play_pos[c] = 0;
		end
		if (played)
			rgt = lft;
		r.out_left = lft[15:0];
		r.out_right = rgt[15:0];
		return r;
	endfunction

	// state change caused by one accepted item
	function automatic void apply_item(input item_t it);
		int unsigned addr;
		int unsigned len;
		addr = int'(it.channel) * MAX_SAMPLES + int'(it.sample_index);
		case (it.opcode)
			OP_WRITE: begin
				if (sound_on && it.channel < CHANNELS && it.sample_index < MAX_SAMPLES) begin
					sample_mem[addr] = it.sample_byte;
					sample_known[addr] = 1'b1;
				end
			end
			OP_START: begin
				if (sound_on && it.channel < CHANNELS) begin
					len = (it.length > MAX_SAMPLES) ? MAX_SAMPLES : it.length;
					frames_left[it.channel] = len * SCALING;
					play_pos[it.channel] = 0;
					chan_volume[it.channel] = it.channel_volume;
				end
			end
			OP_FRAME: expected_mix.push_back(mix_frame(it));
			default: ;
		endcase
	endfunction

	function automatic item_t random_item();
		logic [95:0] bits;
		bits = {$urandom, $urandom, $urandom};
		return bits[$bits(item_t)-1:0];
	endfunction

	function automatic logic signed [15:0] music_value();
		case ($urandom_range(9))
			0: return SAT_HI;
			1: return SAT_LO;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [GAIN_W-1:0] random_volume();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2: return GAIN_UNITY;
			default: return GAIN_W'($urandom);
		endcase
	endfunction

	// mostly short plays, some zero, some long and some past the store size
	function automatic int unsigned random_length();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 10)
			return 0;
		if (pick < 65)
			return $urandom_range(12, 1);
		if (pick < 85)
			return $urandom_range(200, 13);
		if (pick < 95)
			return $urandom_range(LENGTH_MAX, MAX_SAMPLES);
		return $urandom_range(LENGTH_MAX);
	endfunction

	// entered and left on a falling edge; valid stays up if the next transfer follows at once
	task automatic send_item(input item_t it);
		while (!stall_free && $urandom_range(99) < 13) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (!item_ready);
		counted_items++;
		apply_item(it);
		@(negedge clk);
	endtask

	task automatic write_sample(input int ch, input int idx, input logic [7:0] val);
		item_t it;
		it = random_item();
		it.opcode = OP_WRITE;
		it.channel = CH_W'(ch);
		it.sample_index = IDX_W'(idx);
		it.sample_byte = val;
		send_item(it);
	endtask

	task automatic start_channel(input int ch, input int unsigned len,
		input logic [GAIN_W-1:0] vol);
		item_t it;
		it = random_item();
		it.opcode = OP_START;
		it.channel = CH_W'(ch);
		it.length = 13'(len);
		it.channel_volume = vol;
		send_item(it);
	endtask

	task automatic send_noise();
		item_t it;
		it = random_item();
		it.opcode = OP_UNUSED;
		send_item(it);
	endtask

	// fills any byte an active channel is about to read, then sends the frame;
	// with sound off the fill is impossible, so an unsafe frame is skipped
	task automatic play_frame(input logic signed [15:0] ml, input logic signed [15:0] mr);
		item_t it;
		for (int c = 0; c < CHANNELS; c++)
			if (sound_on && frames_left[c] != 0
				&& !sample_known[c * MAX_SAMPLES + read_slot(c)])
				write_sample(c, read_slot(c), 8'($urandom));
		if (frame_safe()) begin
			it = random_item();
			it.opcode = OP_FRAME;
			it.music_left = ml;
			it.music_right = mr;
			send_item(it);
		end
	endtask

	// before sound goes off: short remaining plays get their bytes written,
	// long ones are stopped with a zero-length start
	task automatic secure_playback();
		int unsigned first_slot;
		int unsigned last_slot;
		for (int c = 0; c < CHANNELS; c++) begin
			if (frames_left[c] == 0)
				continue;
			first_slot = play_pos[c] / SCALING;
			last_slot = (play_pos[c] + frames_left[c] - 1) / SCALING;
			if (last_slot - first_slot < 64) begin
				for (int unsigned i = first_slot; i <= last_slot; i++)
					if (!sample_known[c * MAX_SAMPLES + i])
						write_sample(c, i, 8'($urandom));
			end else begin
				start_channel(c, 0, random_volume());
			end
		end
	endtask

	// drop item valid and let every owed frame come out
	task automatic wait_quiet();
		item_valid <= 1'b0;
		while (expected_mix.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// writes all five registers back to back while the block is idle
	task automatic apply_settings(input logic snd, input logic mt, input logic ms,
		input logic [GAIN_W-1:0] mg, input logic [GAIN_W-1:0] eg);
		logic [CFG_IDX_W-1:0] idxs [5];
		logic [GAIN_W-1:0]    vals [5];
		idxs = '{CFG_SOUND_EN, CFG_MUTE, CFG_MUSIC_SCALE, CFG_MUSIC_GAIN, CFG_EFFECT_GAIN};
		vals = '{GAIN_W'(snd), GAIN_W'(mt), GAIN_W'(ms), mg, eg};
		if (sound_on && !snd)
			secure_playback();
		wait_quiet();
		for (int k = 0; k < 5; k++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idxs[k];
			cfg_data <= vals[k];
			do @(posedge clk); while (!cfg_ready);
			store_setting(idxs[k], vals[k]);
			@(negedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	// extremes of every field, each opcode and the documented corner cases
	task automatic test_directed_cases();
		// nothing active: music passes through untouched
		play_frame(SAT_HI, SAT_LO);
		write_sample(0, 0, 8'h7f);
		write_sample(0, 1, 8'h80);
		start_channel(0, 2, '1);
		// largest positive byte at full volume drives left past the top rail
		play_frame(SAT_HI, 16'sd0);
		// same byte held for a second frame, right follows left
		play_frame(16'sd100, -16'sd5);
		// most negative byte pushes past the bottom rail
		play_frame(SAT_LO, 16'sd1);
		play_frame(16'sd0, 16'sd0);
		// channel exhausted: right keeps its own music again
		play_frame(-16'sd1, 16'sd1);
		send_noise();
		// zero length leaves the channel idle
		start_channel(1, 0, GAIN_W'(300));
		play_frame(16'sd1234, -16'sd1234);
		write_sample(7, MAX_SAMPLES - 1, 8'hff);
		write_sample(7, 0, 8'h55);
		// length beyond the store is cut to the store size
		start_channel(7, LENGTH_MAX, GAIN_UNITY);
		play_frame(16'sd0, SAT_HI);
		play_frame(16'sd0, SAT_HI);
		// restart replaces the play state of a running channel
		start_channel(7, 1, '0);
		play_frame(SAT_LO, SAT_HI);
		play_frame(SAT_LO, SAT_HI);
	endtask

	// all channels busy, frames back to back and no backpressure
	task automatic test_back_to_back();
		stall_free = 1'b1;
		for (int c = 0; c < CHANNELS; c++)
			start_channel(c, $urandom_range(16, 4), random_volume());
		repeat (40) play_frame(music_value(), music_value());
		wait_quiet();
		stall_free = 1'b0;
	endtask

	task automatic random_step();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 35)
			// mostly the head of a channel so short plays find their data
			write_sample($urandom_range(CHANNELS - 1),
				($urandom_range(9) < 7) ? $urandom_range(31) : $urandom_range(MAX_SAMPLES - 1),
				8'($urandom));
		else if (pick < 50)
			start_channel($urandom_range(CHANNELS - 1), random_length(), random_volume());
		else if (pick < 95)
			play_frame(music_value(), music_value());
		else
			send_noise();
	endtask

	// random traffic under a sequence of settings, extremes first
	task automatic test_random_phases();
		int goal;
		int phase_goal;
		goal = counted_items + RANDOM_ITEMS;
		for (int phase = 0; counted_items < goal; phase++) begin
			case (phase)
				// muted channels still play out and copy left to right
				0: apply_settings(1'b1, 1'b1, 1'b1, '1, '1);
				1: apply_settings(1'b1, 1'b0, 1'b1, '1, EFFECT_GAIN_MAX);
				2: apply_settings(1'b1, 1'b0, 1'b1, '0, '0);
				// sound off: writes and starts dropped, running channels still mix
				3: apply_settings(1'b0, 1'b0, 1'b0, GAIN_UNITY, GAIN_UNITY);
				// just above the effect gain clamp
				4: apply_settings(1'b1, 1'b0, 1'b0, GAIN_UNITY, GAIN_W'(EFFECT_GAIN_MAX + 1));
				default: apply_settings($urandom_range(9) != 0, $urandom_range(5) == 0,
					1'($urandom_range(1)), GAIN_W'($urandom), GAIN_W'($urandom));
			endcase
			phase_goal = counted_items + PHASE_ITEMS;
			while (counted_items < phase_goal && counted_items < goal)
				random_step();
		end
	endtask

	initial begin
		reset_model();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed_cases();
		test_back_to_back();
		test_random_phases();
		// every owed frame in, then a few more cycles for stray transfers
		wait_quiet();
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// run limit, far above the slowest correct run
	initial begin
		#2000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
